// ===== design/ultrasonic_frame_distance_parser_assert.svh =====
// ----------------------------------------------------------------------------
// Ultrasonic frame distance parser assertion macros
// Shorthand for the clocked implication checks used in the controller.
// ----------------------------------------------------------------------------
`ifndef ULTRASONIC_FRAME_DISTANCE_PARSER_ASSERT_SVH
`define ULTRASONIC_FRAME_DISTANCE_PARSER_ASSERT_SVH

// Same-cycle implication, sampled on clk and disabled while rst_n is low.
`define UFDP_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk and disabled while rst_n is low.
`define UFDP_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/ufdp_pkg.sv =====
// ----------------------------------------------------------------------------
// ufdp_pkg
// Shared constants and controller/datapath interface types.
// ----------------------------------------------------------------------------
package ufdp_pkg;

    localparam int unsigned NUM_SENSORS_DEF = 8;
    localparam int unsigned FRAME_LEN_DEF   = 24;

    localparam logic [7:0]  HEADER_BYTE = 8'h35;
    localparam int unsigned DATA_START  = 8;

    localparam int unsigned DIST_W = 15;
    localparam int unsigned IDX_W  = 3;

    // First scale factor (the divide by 1024 is a shift that truncates toward zero).
    localparam int unsigned MUL_A   = 1600;
    localparam int unsigned SHIFT_A = 10;
    // Second scale factor and its divisor.
    localparam int unsigned MUL_B   = 254;
    localparam int unsigned DIV_B   = 644;
    // floor(2^32 / 644); the quotient estimate is low by at most one.
    localparam int unsigned RECIP_B = 6669203;
    localparam int unsigned RECIP_SH = 32;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic             load_low;
        logic             launch;
        logic [IDX_W-1:0] word_idx;
        logic             last;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic busy;
    } sts_t;

endpackage

// ===== design/ufdp_dp.sv =====
// ----------------------------------------------------------------------------
// ufdp_dp
// Word assembly, four-stage scaling pipeline and result output register.
// ----------------------------------------------------------------------------
module ufdp_dp
    import ufdp_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic [7:0]               rx_byte,
    input  cmd_t                     cmd,
    output sts_t                     sts,
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic signed [DIST_W-1:0] distance_value,
    output logic [IDX_W-1:0]         sensor_index,
    output logic                     last
);

    logic [7:0] low_reg;

    // Stage 1: v * 1600.
    logic               s1_vld_reg;
    logic signed [26:0] s1_prod_reg;
    logic [IDX_W-1:0]   s1_idx_reg;
    logic               s1_last_reg;
    logic signed [15:0] word;
    logic signed [26:0] s1_prod_next;

    // Stage 2: truncate, wrap to 16 bits, times 254.
    logic               s2_vld_reg;
    logic signed [23:0] s2_prod_reg;
    logic [IDX_W-1:0]   s2_idx_reg;
    logic               s2_last_reg;
    logic signed [26:0] quot_a;
    logic signed [15:0] wrapped;
    logic signed [23:0] s2_prod_next;

    // Stage 3: magnitude and reciprocal quotient estimate.
    logic               s3_vld_reg;
    logic [22:0]        s3_mag_reg;
    logic [13:0]        s3_q_reg;
    logic               s3_neg_reg;
    logic [IDX_W-1:0]   s3_idx_reg;
    logic               s3_last_reg;
    logic [22:0]        mag;
    logic [45:0]        q_full;

    // Stage 4: one-step correction into the output register.
    logic                     out_vld_reg;
    logic signed [DIST_W-1:0] dist_reg;
    logic [IDX_W-1:0]         idx_reg;
    logic                     last_reg;
    logic [23:0]              q_times;
    logic [23:0]              rem;
    logic [13:0]              q_fix;
    logic signed [DIST_W-1:0] dist_next;

    assign word         = signed'({rx_byte, low_reg});
    assign s1_prod_next = 27'(word) * 27'(MUL_A);

    // Truncation toward zero: bias negative values before the arithmetic shift.
    assign quot_a = s1_prod_reg[26] ? ((s1_prod_reg + 27'((1 << SHIFT_A) - 1)) >>> SHIFT_A)
                                    : (s1_prod_reg >>> SHIFT_A);
    assign wrapped      = quot_a[15:0];
    assign s2_prod_next = 24'(wrapped) * 24'(MUL_B);

    assign mag    = s2_prod_reg[23] ? 23'(-s2_prod_reg) : 23'(s2_prod_reg);
    assign q_full = 46'(mag) * 46'(RECIP_B);

    assign q_times   = 24'(s3_q_reg) * 24'(DIV_B);
    assign rem       = 24'(s3_mag_reg) - q_times;
    assign q_fix     = (rem >= 24'(DIV_B)) ? s3_q_reg + 14'd1 : s3_q_reg;
    assign dist_next = s3_neg_reg ? -DIST_W'(q_fix) : DIST_W'(q_fix);

    always_ff @(posedge clk)
    begin
        if (cmd.load_low)
        begin
            low_reg <= rx_byte;
        end
        if (cmd.launch)
        begin
            s1_prod_reg <= s1_prod_next;
            s1_idx_reg  <= cmd.word_idx;
            s1_last_reg <= cmd.last;
        end
        if (s1_vld_reg)
        begin
            s2_prod_reg <= s2_prod_next;
            s2_idx_reg  <= s1_idx_reg;
            s2_last_reg <= s1_last_reg;
        end
        if (s2_vld_reg)
        begin
            s3_mag_reg  <= mag;
            s3_q_reg    <= q_full[RECIP_SH +: 14];
            s3_neg_reg  <= s2_prod_reg[23];
            s3_idx_reg  <= s2_idx_reg;
            s3_last_reg <= s2_last_reg;
        end
        if (s3_vld_reg)
        begin
            dist_reg <= dist_next;
            idx_reg  <= s3_idx_reg;
            last_reg <= s3_last_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg  <= 1'b0;
            s2_vld_reg  <= 1'b0;
            s3_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            s1_vld_reg <= cmd.launch;
            s2_vld_reg <= s1_vld_reg;
            s3_vld_reg <= s2_vld_reg;
            // Only one word is ever in flight, so the register is empty here.
            if (s3_vld_reg)
            begin
                out_vld_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    assign sts.busy       = s1_vld_reg | s2_vld_reg | s3_vld_reg | out_vld_reg;
    assign out_valid      = out_vld_reg;
    assign distance_value = dist_reg;
    assign sensor_index   = idx_reg;
    assign last           = last_reg;

endmodule

// ===== design/ufdp_ctrl.sv =====
// ----------------------------------------------------------------------------
// ufdp_ctrl
// Header hunt and frame position state machine; issues datapath commands.
// ----------------------------------------------------------------------------
`include "ultrasonic_frame_distance_parser_assert.svh"

module ufdp_ctrl
    import ufdp_pkg::*;
#(
    parameter int unsigned NUM_SENSORS = NUM_SENSORS_DEF,
    parameter int unsigned FRAME_LEN   = FRAME_LEN_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] rx_byte,
    input  sts_t       sts,
    output cmd_t       cmd
);

    localparam int unsigned POS_W    = $clog2(FRAME_LEN);
    localparam int unsigned DATA_END = DATA_START + 2 * NUM_SENSORS;

    localparam logic ST_HUNT  = 1'b0;
    localparam logic ST_FRAME = 1'b1;

    logic             state_reg, state_next;
    logic             prev_hdr_reg, prev_hdr_next;
    logic [POS_W-1:0] pos_reg, pos_next;

    logic        accept;
    logic        is_hdr;
    logic [31:0] pos_w;
    logic [31:0] offset;
    logic        in_data;
    logic        is_high;

    assign is_hdr  = (rx_byte == HEADER_BYTE);
    assign pos_w   = 32'(pos_reg);
    assign offset  = pos_w - 32'(DATA_START);
    assign in_data = (pos_w >= 32'(DATA_START)) && (pos_w < 32'(DATA_END));
    assign is_high = (state_reg == ST_FRAME) && in_data && offset[0];

    // A word-completing byte waits until the previous result has left.
    assign in_stall = is_high && sts.busy;
    assign accept   = in_valid && !in_stall;

    assign cmd.load_low = accept && (state_reg == ST_FRAME) && in_data && !offset[0];
    assign cmd.launch   = accept && is_high;
    assign cmd.word_idx = offset[IDX_W:1];
    assign cmd.last     = (offset[31:1] == 31'(NUM_SENSORS - 1));

    always_comb
    begin
        state_next    = state_reg;
        prev_hdr_next = prev_hdr_reg;
        pos_next      = pos_reg;
        if (accept)
        begin
            unique case (state_reg)
                ST_HUNT:
                begin
                    if (prev_hdr_reg && is_hdr)
                    begin
                        state_next    = ST_FRAME;
                        pos_next      = POS_W'(2);
                        prev_hdr_next = 1'b0;
                    end
                    else
                    begin
                        prev_hdr_next = is_hdr;
                    end
                end
                ST_FRAME:
                begin
                    if (pos_w + 32'd1 >= 32'(FRAME_LEN))
                    begin
                        state_next    = ST_HUNT;
                        pos_next      = '0;
                        prev_hdr_next = 1'b0;
                    end
                    else
                    begin
                        pos_next = pos_reg + POS_W'(1);
                    end
                end
                default:
                begin
                    state_next = ST_HUNT;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_HUNT;
            prev_hdr_reg <= 1'b0;
            pos_reg      <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            prev_hdr_reg <= prev_hdr_next;
            pos_reg      <= pos_next;
        end
    end

    `UFDP_ASSERT_IMP(a_launch_in_frame, cmd.launch, state_reg == ST_FRAME, "launch outside frame")
    `UFDP_ASSERT_IMP(a_launch_idle, cmd.launch, !sts.busy, "launch while datapath busy")
    `UFDP_ASSERT_IMP(a_stall_busy, in_stall, sts.busy && is_high, "stall without cause")
    `UFDP_ASSERT_NXT(a_frame_start, accept && state_reg == ST_HUNT && prev_hdr_reg && is_hdr,
        state_reg == ST_FRAME && pos_reg == POS_W'(2), "frame start missed")

endmodule

// ===== design/ultrasonic_frame_distance_parser.sv =====
// ----------------------------------------------------------------------------
// ultrasonic_frame_distance_parser
// Finds 0x35 0x35 framed sensor packets in a byte stream and emits one scaled
// distance per sensor word.
// ----------------------------------------------------------------------------
//
//  Channel  Direction  Handshake            Payload
//  -------  ---------  -------------------  ------------------------------------
//  in       input      in_valid / in_stall   rx_byte[7:0]
//  out      output     out_valid / out_stall distance_value[14:0] (signed),
//                                            sensor_index[2:0], last
//
// Header, skipped and low data bytes are taken at one transfer per cycle.
// The byte that completes a sensor word is held off (in_stall) while the
// previous word is still in the scaling pipeline or waiting in the output
// register; its result moves through the scaling stages into the output
// register and is presented on out, so only one word is in flight at a time.
// The pipeline is four registered stages: v*1600, truncate/wrap and *254,
// a reciprocal quotient estimate for the divide by 644, and a correction.
// Reset is asynchronous and active low; it returns the block to hunting for
// a header and empties the pipeline. There is no clearing pass.
// A stall on out holds the result; low and skipped bytes still flow in.
//
module ultrasonic_frame_distance_parser
    import ufdp_pkg::*;
#(
    parameter int unsigned NUM_SENSORS = NUM_SENSORS_DEF,
    parameter int unsigned FRAME_LEN   = FRAME_LEN_DEF
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic [7:0]               rx_byte,
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic signed [DIST_W-1:0] distance_value,
    output logic [IDX_W-1:0]         sensor_index,
    output logic                     last
);

    // Command and status buses between the controller and the datapath.
    cmd_t cmd;
    sts_t sts;

    // The controller tracks header hunting and the position within a frame,
    // and decides which bytes are stored and which start a scaling pass.
    ufdp_ctrl #(
        .NUM_SENSORS (NUM_SENSORS),
        .FRAME_LEN   (FRAME_LEN)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .rx_byte  (rx_byte),
        .sts      (sts),
        .cmd      (cmd)
    );

    // The datapath assembles each word, scales it and holds the result until
    // the downstream side completes the transfer.
    ufdp_dp u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .rx_byte        (rx_byte),
        .cmd            (cmd),
        .sts            (sts),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .distance_value (distance_value),
        .sensor_index   (sensor_index),
        .last           (last)
    );

endmodule

// ===== verif/testbench.sv =====
// ----------------------------------------------------------------------------
// Testbench for the ultrasonic frame distance parser
// Drives a serial byte stream through the input channel and checks every
// distance transfer against a cycle-free model of the frame parser and of
// the two-stage scaling. A short directed table comes first, then random
// frames mixed with noise, broken headers and header runs, with idling and
// long stalls on both channels.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
    import ufdp_pkg::*;

    // Geometry of the frame under test; the block is built with the same values.
    localparam int SENSORS     = 8;
    localparam int FRAME_BYTES = 24;
    localparam int FIRST_WORD  = 8;

    // Scaling factors, kept signed so that the divides truncate toward zero.
    localparam longint SCALE_A_MUL = 1600;
    localparam longint SCALE_A_DIV = 1024;
    localparam longint SCALE_B_MUL = 254;
    localparam longint SCALE_B_DIV = 644;

    localparam int IDLE_PCT       = 25;
    // Total byte transfers of the whole run, directed table included.
    localparam int RANDOM_ITEMS   = 400;
    localparam int HOLD_CYCLES    = 300;
    // Slack waited out after the last expected distance has left the block.
    localparam int DRAIN_CYCLES   = 16;
    // Longest correct quiet spell is the receiver hold-off; allow several times it.
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DIR_ROWS       = 26;

    // One distance transfer as the output channel presents it.
    typedef struct packed {
        logic signed [DIST_W-1:0] dist_val;
        logic [IDX_W-1:0]         idx;
        logic                     last;
    } distance_rec_t;

    // One row of the directed table. Where known is set, the expected
    // distance is written into the row rather than taken from the model.
    typedef struct packed {
        logic [7:0]    rx;
        logic          known;
        distance_rec_t want;
    } stim_row_t;

    logic                     clk;
    logic                     rst_n;
    logic                     in_valid;
    logic                     in_stall;
    logic [7:0]               rx_byte;
    logic                     out_valid;
    logic                     out_stall;
    logic signed [DIST_W-1:0] distance_value;
    logic [IDX_W-1:0]         sensor_index;
    logic                     last;

    // Model state of the frame parser.
    bit         hunt_hdr_seen;
    bit         in_frame_m;
    int         frame_pos;
    logic [7:0] word_low;

    distance_rec_t pending_distances[$];

    int  mismatches;
    int  bytes_moved;
    int  distances_seen;
    int  frames_started;
    int  framed_bytes;
    int  quiet_cycles;

    // Shared between the sender and the receiver.
    bit  calm;
    bit  hold_req;

    // The directed table. The frame opens with a header run, so its third
    // 0x35 is already frame byte 2. A 0x35 among the skipped bytes and a
    // 0x3535 word show that headers inside a frame are plain data. The last
    // frame byte is 0x35 too, so leaving the frame must not leave a header
    // behind. The words cover zero, both extremes and minus one.
    stim_row_t dir_table [DIR_ROWS] = '{
        '{8'h35, 1'b0, '0},                     // lone header ...
        '{8'h00, 1'b0, '0},                     // ... broken off
        '{8'h35, 1'b0, '0},
        '{8'h35, 1'b0, '0},                     // frame starts here
        '{8'h35, 1'b0, '0},                     // header run: frame byte 2
        '{8'hA5, 1'b0, '0},
        '{8'h5A, 1'b0, '0},
        '{8'hFF, 1'b0, '0},
        '{8'h00, 1'b0, '0},
        '{8'h35, 1'b0, '0},                     // frame byte 7, still skipped
        '{8'h00, 1'b0, '0},
        '{8'h00, 1'b1, '{15'sd0, 3'd0, 1'b0}},  // word 0x0000 gives zero
        '{8'hFF, 1'b0, '0},
        '{8'h7F, 1'b0, '0},                     // most positive word
        '{8'h00, 1'b0, '0},
        '{8'h80, 1'b0, '0},                     // most negative word
        '{8'hFF, 1'b0, '0},
        '{8'hFF, 1'b1, '{15'sd0, 3'd3, 1'b0}},  // minus one truncates to zero
        '{8'h35, 1'b0, '0},
        '{8'h35, 1'b0, '0},                     // header bytes as a data word
        '{8'h01, 1'b0, '0},
        '{8'h00, 1'b1, '{15'sd0, 3'd5, 1'b0}},  // plus one truncates to zero
        '{8'h01, 1'b0, '0},
        '{8'h80, 1'b0, '0},
        '{8'h00, 1'b0, '0},
        '{8'h35, 1'b0, '0}                      // last word, last byte 0x35
    };

    ultrasonic_frame_distance_parser #(
        .NUM_SENSORS (SENSORS),
        .FRAME_LEN   (FRAME_BYTES)
    ) dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .rx_byte        (rx_byte),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .distance_value (distance_value),
        .sensor_index   (sensor_index),
        .last           (last)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // Scale one raw sensor word to hundredths: first by 1600/1024 with the
    // result wrapped back to 16 bits, then by 254/644, each step truncating
    // toward zero.
    function automatic logic signed [DIST_W-1:0] scale_to_hundredths(
        input logic signed [15:0] raw);
        longint            stage_a;
        logic signed [15:0] wrapped;
        longint            stage_b;
        stage_a = (longint'(raw) * SCALE_A_MUL) / SCALE_A_DIV;
        wrapped = stage_a[15:0];
        stage_b = (longint'(wrapped) * SCALE_B_MUL) / SCALE_B_DIV;
        return stage_b[DIST_W-1:0];
    endfunction

    // Advance the parser model by one accepted byte. While hunting, two
    // consecutive header bytes open a frame at position 2. Inside a frame,
    // the bytes from FIRST_WORD on pair up low byte first into sensor words,
    // and the high byte of each pair yields one distance.
    task automatic step_frame_parser(input logic [7:0] b, output bit produced,
                                     output distance_rec_t rec);
        int k;
        produced = 1'b0;
        rec      = '0;
        if (!in_frame_m) begin
            if (hunt_hdr_seen && b == HEADER_BYTE) begin
                in_frame_m    = 1'b1;
                frame_pos     = 2;
                hunt_hdr_seen = 1'b0;
                frames_started++;
            end
            else begin
                hunt_hdr_seen = (b == HEADER_BYTE);
            end
        end
        else begin
            if (frame_pos >= FIRST_WORD && frame_pos < FIRST_WORD + 2 * SENSORS) begin
                k = (frame_pos - FIRST_WORD) >> 1;
                if (((frame_pos - FIRST_WORD) & 1) == 0) begin
                    word_low = b;
                end
                else begin
                    rec.dist_val = scale_to_hundredths({b, word_low});
                    rec.idx      = k[IDX_W-1:0];
                    rec.last     = (k == SENSORS - 1);
                    produced     = 1'b1;
                end
            end
            if (frame_pos + 1 >= FRAME_BYTES) begin
                in_frame_m    = 1'b0;
                frame_pos     = 0;
                hunt_hdr_seen = 1'b0;
            end
            else begin
                frame_pos++;
            end
        end
    endtask

    task automatic report_mismatch(input string what, input distance_rec_t got,
                                   input distance_rec_t want);
        mismatches++;
        $display("%0t mismatch: %s got dist=%0d idx=%0d last=%0b want dist=%0d idx=%0d last=%0b",
                 $realtime, what, got.dist_val, got.idx, got.last,
                 want.dist_val, want.idx, want.last);
    endtask

    // Offer one byte on the input channel and hold it until the transfer
    // happens, then update the model. Idle cycles are put in front of the
    // byte at random unless the calm stretch is running. The channel signals
    // are driven nonblocking, at most once per signal per edge.
    task automatic offer_byte(input logic [7:0] b, input bit known,
                              input distance_rec_t typed);
        bit            produced;
        bit            was_framing;
        distance_rec_t rec;
        while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
            in_valid <= 1'b0;
            rx_byte  <= 8'($urandom_range(0, 255));
            @(posedge clk);
        end
        in_valid <= 1'b1;
        rx_byte  <= b;
        @(posedge clk);
        // in_stall is read at the edge, before this edge's updates land, so
        // leaving the loop means the byte was taken at this edge.
        while (in_stall) @(posedge clk);
        bytes_moved++;
        was_framing = in_frame_m;
        step_frame_parser(b, produced, rec);
        if (was_framing || in_frame_m) framed_bytes++;
        if (known) begin
            rec      = typed;
            produced = 1'b1;
        end
        if (produced) pending_distances.push_back(rec);
    endtask

    // Data bytes lean towards the values that build extreme words and
    // stray header codes.
    function automatic logic [7:0] pick_data_byte();
        logic [7:0] special [5] = '{8'h00, 8'hFF, 8'h7F, 8'h80, HEADER_BYTE};
        if ($urandom_range(0, 99) < 20) return special[$urandom_range(0, 4)];
        return 8'($urandom_range(0, 255));
    endfunction

    task automatic send_frame();
        int i;
        offer_byte(HEADER_BYTE, 1'b0, '0);
        offer_byte(HEADER_BYTE, 1'b0, '0);
        for (i = 2; i < FRAME_BYTES; i++) offer_byte(pick_data_byte(), 1'b0, '0);
    endtask

    // Sender pause: stop offering until every expected distance is out.
    task automatic pause_for_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_distances.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Output side: compare each distance transfer with the oldest
    // expectation, field by field through the packed record.
    always @(posedge clk) begin
        distance_rec_t got;
        distance_rec_t want;
        if (rst_n && out_valid && !out_stall) begin
            got = '{distance_value, sensor_index, last};
            distances_seen++;
            if (pending_distances.size() == 0) begin
                report_mismatch("unexpected distance", got, '0);
            end
            else begin
                want = pending_distances.pop_front();
                if (got !== want) report_mismatch("distance", got, want);
            end
        end
    end

    // Receiver: random stalls, none during the calm stretch, and one long
    // hold-off on request so that the block fills and stalls its input.
    initial begin
        out_stall = 1'b0;
        @(posedge rst_n);
        forever begin
            @(posedge clk);
            if (hold_req) begin
                hold_req = 1'b0;
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            out_stall <= calm ? 1'b0 : ($urandom_range(0, 99) < IDLE_PCT);
        end
    end

    // Watchdog: too many cycles in a row without any transfer ends the run.
    initial begin
        quiet_cycles = 0;
        while (quiet_cycles < WATCHDOG_LIMIT) begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles = 0;
            else quiet_cycles++;
        end
        $display("timeout after %0d cycles without a transfer", WATCHDOG_LIMIT);
        $display("CHECK FAILED");
        $finish;
    end

    // Main sequence: reset, directed table, random stream, drain and verdict.
    initial begin
        int  row;
        int  pick;
        int  n;
        bit  hold_issued;
        bit  pause_issued;
        logic [7:0] stray;

        rst_n         = 1'b0;
        in_valid      = 1'b0;
        rx_byte       = 8'h00;
        calm          = 1'b0;
        hold_req      = 1'b0;
        hunt_hdr_seen = 1'b0;
        in_frame_m    = 1'b0;
        frame_pos     = 0;
        word_low      = 8'h00;
        mismatches    = 0;
        bytes_moved   = 0;
        distances_seen = 0;
        frames_started = 0;
        framed_bytes  = 0;
        hold_issued   = 1'b0;
        pause_issued  = 1'b0;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (row = 0; row < DIR_ROWS; row++)
            offer_byte(dir_table[row].rx, dir_table[row].known, dir_table[row].want);

        // Let the directed frame drain before the random stream starts.
        pause_for_results();
        framed_bytes = 0;

        while (bytes_moved < RANDOM_ITEMS) begin
            if (!hold_issued && bytes_moved >= 150) begin
                hold_req    = 1'b1;
                hold_issued = 1'b1;
            end
            if (!pause_issued && bytes_moved >= 250) begin
                pause_for_results();
                pause_issued = 1'b1;
            end
            calm = (bytes_moved >= 290 && bytes_moved < 360);
            pick = $urandom_range(0, 99);
            if (pick < 70) begin
                send_frame();
            end
            else if (pick < 80) begin
                // Header run: the extra 0x35 in front shifts the frame by one.
                offer_byte(HEADER_BYTE, 1'b0, '0);
                send_frame();
            end
            else if (pick < 90) begin
                n = $urandom_range(1, 6);
                repeat (n) offer_byte(8'($urandom_range(0, 255)), 1'b0, '0);
            end
            else begin
                // Broken header: one 0x35 followed by anything else.
                do stray = 8'($urandom_range(0, 255)); while (stray == HEADER_BYTE);
                offer_byte(HEADER_BYTE, 1'b0, '0);
                offer_byte(stray, 1'b0, '0);
            end
        end
        calm = 1'b0;

        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_distances.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("run covered %0d byte transfers (%0d random ones inside frames), %0d frames",
                 bytes_moved, framed_bytes, frames_started);
        $display("and %0d distances, with a long output hold-off, a drain pause and calm",
                 distances_seen);
        if (mismatches == 0) begin
            $display("CHECK OK");
        end
        else begin
            $display("%0d mismatches", mismatches);
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
